>>> rtl/core/cpc_pkg.sv
// shared constants for the cylinder point counter
// codes for operations, registers, end modes and the arithmetic sequence
// no dependencies
`default_nettype none

package cpc_pkg;

  // input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_AXIS     = 2'd1;
  localparam logic [1:0] REG_MIN_PTS  = 2'd2;
  localparam logic [1:0] REG_END_MODE = 2'd3;

  localparam int CFG_BITS = 24;

  // register reset values
  localparam logic [23:0] RADIUS_RST  = 24'd1280;
  localparam logic [23:0] AXIS_RST    = 24'd12800;
  localparam logic [15:0] MIN_PTS_RST = 16'd10;

  // end modes
  localparam logic [1:0] MODE_BOT_YZ    = 2'd0;
  localparam logic [1:0] MODE_BOT_YZ_XZ = 2'd1;
  localparam logic [1:0] MODE_TOP_YZ_XZ = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  // multiplier digit width
  localparam int DIGIT_BITS = 16;

  // arithmetic sequence, one multiply each
  localparam logic [3:0] SEQ_R2 = 4'd0;   // radius squared
  localparam logic [3:0] SEQ_A2 = 4'd1;   // axis squared
  localparam logic [3:0] SEQ_L0 = 4'd2;   // len2 = da*da
  localparam logic [3:0] SEQ_L1 = 4'd3;   // len2 += dz*dz
  localparam logic [3:0] SEQ_D0 = 4'd4;   // dot = wa*da
  localparam logic [3:0] SEQ_D1 = 4'd5;   // dot += wz*dz
  localparam logic [3:0] SEQ_C0 = 4'd6;   // crs = wa*dz
  localparam logic [3:0] SEQ_C1 = 4'd7;   // crs -= wz*da
  localparam logic [3:0] SEQ_QC = 4'd8;   // crs squared
  localparam logic [3:0] SEQ_CR = 4'd9;   // r2*len2, radius test
  localparam logic [3:0] SEQ_QD = 4'd10;  // dot squared
  localparam logic [3:0] SEQ_CA = 4'd11;  // a2*len2, axis test

endpackage

`default_nettype wire

>>> rtl/core/cylinder_point_counter_top.sv
// cylinder point counter, top level
// one shared digit-serial multiplier under a small sequencer
// depends on cpc_pkg
`default_nettype none

// A start transaction (tuser low) loads the track end point E from the point
// fields and the direction E - R from the reference fields, clears the count
// and gives no result. Each space point transaction (tuser high) is tested
// against the cylinder around the track line in the YZ plane, and in the XZ
// plane too for end modes one and two, using exact squared distances: with
// w = P - E and d = E - R, L = |d|^2, a point is inside when cross(w,d)^2 <
// radius^2 * L and dot(w,d)^2 < axis^2 * L, L is nonzero, and P lies on the
// required side of E in Y. The space point with tlast high returns the
// count (saturating) in tdata and the bad flag (count > min_points) in tuser.
// All products go through one multiplier that takes OPW x 16 bits a cycle;
// a multiply works through NDIG digits and then a combine step, with
// NDIG = ceil(OPW/16) and OPW = max(2*COORD_BITS+2, 48). A space point runs
// 12 multiplies for one plane or 22 for two, with NDIG = 4 at the defaults;
// mode three and start items run no multiply. The input is not ready while
// a point is worked on; a finished result waits in the output register
// while the next input is taken.
module cylinder_point_counter_top #(
  parameter int COORD_BITS = 24,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_wr_en,
  input  wire logic [1:0]                     cfg_addr,
  input  wire logic [cpc_pkg::CFG_BITS-1:0]   cfg_wdata,
  // input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // point_x, point_y, point_z, ref_x, ref_y, ref_z
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // operation
  input  wire logic                           s_tuser,
  // last_point
  input  wire logic                           s_tlast,
  // result stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // point_count
  output logic [((COUNT_BITS+7)/8)*8-1:0]     m_tdata,
  // bad_track
  output logic                                m_tuser
);

  localparam int C     = COORD_BITS;
  localparam int OPW   = (2*C+2 > 48) ? 2*C+2 : 48;
  localparam int DW    = cpc_pkg::DIGIT_BITS;
  localparam int NDIG  = (OPW + DW - 1) / DW;
  localparam int BPW   = NDIG * DW;
  localparam int DGW   = $clog2(NDIG);
  localparam int OUTW  = ((COUNT_BITS+7)/8)*8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_COMB = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // configuration registers
  logic [23:0] radius_limit;
  logic [23:0] axis_limit;
  logic [15:0] min_points;
  logic [1:0]  end_mode;

  // track line and count
  logic signed [C-1:0] end_point [3];
  logic signed [C:0]   direction [3];
  logic [COUNT_BITS-1:0] inside_count;

  // current point
  logic signed [C-1:0] pt [3];
  logic                last_reg;

  // sequencer
  logic [1:0]     state;
  logic [3:0]     seq;
  logic           plane;
  logic [DGW-1:0] dig;
  logic           ok;

  // arithmetic registers
  logic [2*OPW-1:0]      acc;
  logic [OPW-1:0]        len2;
  logic [OPW-1:0]        r2;
  logic [OPW-1:0]        a2;
  logic signed [OPW:0]   dot;
  logic signed [OPW:0]   crs;
  logic [2*OPW-1:0]      sq;

  // input fields
  logic signed [C-1:0] in_pt  [3];
  logic signed [C-1:0] in_ref [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pt[i]  = s_tdata[i*C +: C];
      in_ref[i] = s_tdata[(i+3)*C +: C];
    end
  end

  // per-plane operands
  logic signed [C:0] wa, wz, da, dz;
  always_comb begin
    wa = (C+1)'(pt[plane ? 0 : 1]) - (C+1)'(end_point[plane ? 0 : 1]);
    wz = (C+1)'(pt[2]) - (C+1)'(end_point[2]);
    da = direction[plane ? 0 : 1];
    dz = direction[2];
  end

  function automatic logic [OPW-1:0] mag_of(input logic signed [OPW:0] v);
    logic signed [OPW:0] n;
    n = -v;
    return v[OPW] ? n[OPW-1:0] : v[OPW-1:0];
  endfunction

  // operand select for the shared multiplier
  logic signed [OPW:0] op_a_s, op_b_s;
  logic                op_neg;
  always_comb begin
    op_neg = 1'b0;
    case (seq)
      cpc_pkg::SEQ_R2: begin
        op_a_s = (OPW+1)'(radius_limit);
        op_b_s = (OPW+1)'(radius_limit);
      end
      cpc_pkg::SEQ_A2: begin
        op_a_s = (OPW+1)'(axis_limit);
        op_b_s = (OPW+1)'(axis_limit);
      end
      cpc_pkg::SEQ_L0: begin
        op_a_s = (OPW+1)'(da);
        op_b_s = (OPW+1)'(da);
      end
      cpc_pkg::SEQ_L1: begin
        op_a_s = (OPW+1)'(dz);
        op_b_s = (OPW+1)'(dz);
      end
      cpc_pkg::SEQ_D0: begin
        op_a_s = (OPW+1)'(wa);
        op_b_s = (OPW+1)'(da);
      end
      cpc_pkg::SEQ_D1: begin
        op_a_s = (OPW+1)'(wz);
        op_b_s = (OPW+1)'(dz);
      end
      cpc_pkg::SEQ_C0: begin
        op_a_s = (OPW+1)'(wa);
        op_b_s = (OPW+1)'(dz);
      end
      cpc_pkg::SEQ_C1: begin
        op_a_s = (OPW+1)'(wz);
        op_b_s = (OPW+1)'(da);
        op_neg = 1'b1;
      end
      cpc_pkg::SEQ_QC: begin
        op_a_s = crs;
        op_b_s = crs;
      end
      cpc_pkg::SEQ_CR: begin
        op_a_s = (OPW+1)'(r2);
        op_b_s = (OPW+1)'(len2);
      end
      cpc_pkg::SEQ_QD: begin
        op_a_s = dot;
        op_b_s = dot;
      end
      cpc_pkg::SEQ_CA: begin
        op_a_s = (OPW+1)'(a2);
        op_b_s = (OPW+1)'(len2);
      end
      default: begin
        op_a_s = '0;
        op_b_s = '0;
      end
    endcase
  end

  logic [OPW-1:0]    op_a;
  logic [BPW-1:0]    op_b;
  logic              prod_neg;
  logic [DW-1:0]     digit;
  logic [OPW+DW-1:0] part;
  logic [2*OPW-1:0]  acc_next;

  assign op_a     = mag_of(op_a_s);
  assign op_b     = BPW'(mag_of(op_b_s));
  assign prod_neg = op_a_s[OPW] ^ op_b_s[OPW] ^ op_neg;
  assign digit    = op_b[dig*DW +: DW];
  // one digit a cycle, most significant first
  assign part     = (OPW+DW)'(op_a) * (OPW+DW)'(digit);
  assign acc_next = (acc << DW) + (2*OPW)'(part);

  // signed product for the accumulate steps
  logic signed [OPW:0] sprod;
  assign sprod = prod_neg ? -(OPW+1)'(acc) : (OPW+1)'(acc);

  logic two_planes;
  assign two_planes = (end_mode == cpc_pkg::MODE_BOT_YZ_XZ) ||
                      (end_mode == cpc_pkg::MODE_TOP_YZ_XZ);

  // side test on the incoming point
  logic side_ok;
  assign side_ok = (end_mode == cpc_pkg::MODE_TOP_YZ_XZ) ? (end_point[1] < in_pt[1])
                                                         : (end_point[1] > in_pt[1]);

  // count update at the end of a point
  logic [COUNT_BITS-1:0] count_new;
  logic                  out_free;
  assign count_new = (ok && (inside_count != '1)) ? inside_count + 1'b1 : inside_count;
  assign out_free  = !m_tvalid || m_tready;

  assign s_tready = (state == ST_IDLE);

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_limit <= cpc_pkg::RADIUS_RST;
      axis_limit   <= cpc_pkg::AXIS_RST;
      min_points   <= cpc_pkg::MIN_PTS_RST;
      end_mode     <= cpc_pkg::MODE_BOT_YZ;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        cpc_pkg::REG_RADIUS:   radius_limit <= cfg_wdata[23:0];
        cpc_pkg::REG_AXIS:     axis_limit   <= cfg_wdata[23:0];
        cpc_pkg::REG_MIN_PTS:  min_points   <= cfg_wdata[15:0];
        cpc_pkg::REG_END_MODE: end_mode     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // sequencer and track state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seq          <= cpc_pkg::SEQ_R2;
      plane        <= 1'b0;
      dig          <= '0;
      ok           <= 1'b0;
      inside_count <= '0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        end_point[i] <= '0;
        direction[i] <= '0;
      end
    end else begin
      // a new result loaded this cycle keeps valid high
      if (m_tvalid && m_tready && !((state == ST_DONE) && last_reg)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_tuser == cpc_pkg::OP_START) begin
              for (int i = 0; i < 3; i++) begin
                end_point[i] <= in_pt[i];
                direction[i] <= (C+1)'(in_pt[i]) - (C+1)'(in_ref[i]);
              end
              inside_count <= '0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                pt[i] <= in_pt[i];
              end
              last_reg <= s_tlast;
              plane    <= 1'b0;
              seq      <= cpc_pkg::SEQ_R2;
              dig      <= DGW'(NDIG-1);
              acc      <= '0;
              if (end_mode == cpc_pkg::MODE_NONE) begin
                ok    <= 1'b0;
                state <= ST_DONE;
              end else begin
                ok    <= side_ok;
                state <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          acc <= acc_next;
          dig <= dig - 1'b1;
          if (dig == '0) begin
            state <= ST_COMB;
          end
        end
        ST_COMB: begin
          case (seq)
            cpc_pkg::SEQ_R2: r2   <= acc[OPW-1:0];
            cpc_pkg::SEQ_A2: a2   <= acc[OPW-1:0];
            cpc_pkg::SEQ_L0: len2 <= acc[OPW-1:0];
            cpc_pkg::SEQ_L1: len2 <= len2 + acc[OPW-1:0];
            cpc_pkg::SEQ_D0: dot  <= sprod;
            cpc_pkg::SEQ_D1: dot  <= dot + sprod;
            cpc_pkg::SEQ_C0: crs  <= sprod;
            cpc_pkg::SEQ_C1: crs  <= crs + sprod;
            cpc_pkg::SEQ_QC: sq   <= acc;
            cpc_pkg::SEQ_CR: ok   <= ok && (len2 != '0) && (sq < acc);
            cpc_pkg::SEQ_QD: sq   <= acc;
            cpc_pkg::SEQ_CA: ok   <= ok && (sq < acc);
            default: ;
          endcase
          acc <= '0;
          dig <= DGW'(NDIG-1);
          if (seq == cpc_pkg::SEQ_CA) begin
            if (!plane && two_planes) begin
              plane <= 1'b1;
              seq   <= cpc_pkg::SEQ_L0;
              state <= ST_MUL;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            seq   <= seq + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (!last_reg) begin
            inside_count <= count_new;
            state        <= ST_IDLE;
          end else if (out_free) begin
            // result goes out, count restarts
            m_tvalid     <= 1'b1;
            m_tdata      <= OUTW'(count_new);
            m_tuser      <= 32'(count_new) > 32'(min_points);
            inside_count <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result appears only from the end of a last point
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE) && $past(last_reg))
    else $error("result without a last point");

  // a zero-length projected direction never counts
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMB) && (seq == cpc_pkg::SEQ_CR) && (len2 == '0) |=> !ok)
    else $error("degenerate line counted");

  // a start transaction clears the count
  assert property (@(posedge clk) disable iff (rst)
    in_acc && (s_tuser == cpc_pkg::OP_START) |=> (inside_count == '0))
    else $error("count not cleared on start");

endmodule

`default_nettype wire
